### rtl/pfc_pkg.sv
package pfc_pkg;

  // Debounced paper state codes
  typedef logic [1:0] paper_state_t;
  localparam paper_state_t ST_IDLE      = 2'd0;
  localparam paper_state_t ST_NO_PAPER  = 2'd1;
  localparam paper_state_t ST_HAS_PAPER = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_DEBOUNCE_LIMIT = 1'b0;
  localparam cfg_idx_t REG_RUN_TICKS      = 1'b1;

  localparam int unsigned CNT_W = 16;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam cnt_t DEBOUNCE_LIMIT_RST = 16'd10;
  localparam cnt_t RUN_TICKS_RST      = 16'd100;
  localparam cnt_t CNT_MAX            = 16'hFFFF;

  // Configuration as seen by the datapath
  typedef struct packed {
    cnt_t debounce_limit;
    cnt_t run_ticks;
  } pfc_cfg_t;

endpackage

### rtl/pfc_debounce.sv
module pfc_debounce (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic                  level,
  input  pfc_pkg::pfc_cfg_t     cfg,
  output pfc_pkg::paper_state_t state_nxt
);

  pfc_pkg::cnt_t         low_cnt_r, low_cnt_nxt;
  pfc_pkg::cnt_t         high_cnt_r, high_cnt_nxt;
  pfc_pkg::paper_state_t state_r;

  // Count the run of equal samples; fire and clear once past the limit
  always_comb begin
    low_cnt_nxt  = low_cnt_r;
    high_cnt_nxt = high_cnt_r;
    state_nxt    = state_r;
    if (!level) begin
      high_cnt_nxt = '0;
      if (low_cnt_r >= cfg.debounce_limit) begin
        low_cnt_nxt = '0;
        state_nxt   = pfc_pkg::ST_NO_PAPER;
      end else begin
        low_cnt_nxt = low_cnt_r + 1'b1;
      end
    end else begin
      low_cnt_nxt = '0;
      if (high_cnt_r >= cfg.debounce_limit) begin
        high_cnt_nxt = '0;
        state_nxt    = pfc_pkg::ST_HAS_PAPER;
      end else begin
        high_cnt_nxt = high_cnt_r + 1'b1;
      end
    end
  end

  // Advance only when a sample word is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_cnt_r  <= '0;
      high_cnt_r <= '0;
      state_r    <= pfc_pkg::ST_IDLE;
    end else if (step) begin
      low_cnt_r  <= low_cnt_nxt;
      high_cnt_r <= high_cnt_nxt;
      state_r    <= state_nxt;
    end
  end

  a_one_run_active: assert property (@(posedge clk) disable iff (!rst_n)
    !((low_cnt_r != '0) && (high_cnt_r != '0)))
    else $error("low and high run counters both non-zero");

  a_no_idle_after_fire: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != pfc_pkg::ST_IDLE) |=> (state_r != pfc_pkg::ST_IDLE))
    else $error("debounced state fell back to idle");

endmodule

### rtl/pfc_feed.sv
module pfc_feed (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  pfc_pkg::paper_state_t state_nxt,
  input  pfc_pkg::pfc_cfg_t     cfg,
  output logic                  motor_nxt
);

  logic          started_r, started_nxt;
  logic          finished_r, finished_nxt;
  logic          armed_r, armed_nxt;
  logic          motor_r;
  pfc_pkg::cnt_t timer_r, timer_nxt;
  pfc_pkg::cnt_t timer_base;

  // Start a feed on no-paper; on has-paper run the timer and stop the motor once it reaches the run time
  always_comb begin
    started_nxt  = started_r;
    finished_nxt = finished_r;
    armed_nxt    = armed_r;
    motor_nxt    = motor_r;
    timer_nxt    = timer_r;
    timer_base   = armed_r ? timer_r : '0;
    case (state_nxt)
      pfc_pkg::ST_NO_PAPER: begin
        if (!started_r) begin
          started_nxt  = 1'b1;
          finished_nxt = 1'b0;
          armed_nxt    = 1'b0;
          motor_nxt    = 1'b1;
        end
      end
      pfc_pkg::ST_HAS_PAPER: begin
        armed_nxt = 1'b1;
        timer_nxt = (timer_base != pfc_pkg::CNT_MAX) ? timer_base + 1'b1 : timer_base;
        if ((timer_nxt >= cfg.run_ticks) && !finished_r) begin
          started_nxt  = 1'b0;
          finished_nxt = 1'b1;
          motor_nxt    = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r  <= 1'b0;
      finished_r <= 1'b0;
      armed_r    <= 1'b0;
      motor_r    <= 1'b0;
      timer_r    <= '0;
    end else if (step) begin
      started_r  <= started_nxt;
      finished_r <= finished_nxt;
      armed_r    <= armed_nxt;
      motor_r    <= motor_nxt;
      timer_r    <= timer_nxt;
    end
  end

  a_motor_tracks_feed: assert property (@(posedge clk) disable iff (!rst_n)
    motor_r == started_r)
    else $error("motor drive out of step with feed state");

  a_finish_needs_timer: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |-> armed_r)
    else $error("feed finished without an armed timer");

endmodule

### rtl/paper_feed_controller.sv
// Paper feed controller: takes one sensor sample word per tick and returns one result
// word (motor drive and debounced paper state) per sample. A new sample can be taken
// every cycle while the result side is not stalled; the sample is accepted into the input
// register, and the single update stage then moves it into the result register, which
// offers it. A stalled result side holds both registers.
// The state update is one pass through the run counters, the debounced state and the
// feed timer. Configuration writes take effect at once and must only be made while no
// sample is in flight.
module paper_feed_controller (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_sensor_level,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_motor_forward,
  output logic [1:0]            out_paper_state,
  input  logic                  cfg_we,
  input  pfc_pkg::cfg_idx_t     cfg_index,
  input  pfc_pkg::cnt_t         cfg_wdata
);

  pfc_pkg::pfc_cfg_t     cfg_r;
  logic                  smp_vld_r;
  logic                  smp_lvl_r;
  logic                  res_vld_r;
  logic                  res_motor_r;
  pfc_pkg::paper_state_t res_state_r;
  logic                  res_free;
  logic                  step;
  pfc_pkg::paper_state_t state_nxt;
  logic                  motor_nxt;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_limit <= pfc_pkg::DEBOUNCE_LIMIT_RST;
      cfg_r.run_ticks      <= pfc_pkg::RUN_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pfc_pkg::REG_DEBOUNCE_LIMIT: cfg_r.debounce_limit <= cfg_wdata;
        pfc_pkg::REG_RUN_TICKS:      cfg_r.run_ticks      <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Pipeline handshake: result slot frees when empty or being taken
  assign res_free = !res_vld_r || out_ready;
  assign step     = smp_vld_r && res_free;
  assign in_ready = !smp_vld_r || res_free;

  // Input register: hold the sample word until the update stage takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_vld_r <= 1'b0;
    end else if (in_ready) begin
      smp_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      smp_lvl_r <= in_sensor_level;
    end
  end

  pfc_debounce u_debounce (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .level     (smp_lvl_r),
    .cfg       (cfg_r),
    .state_nxt (state_nxt)
  );

  pfc_feed u_feed (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .state_nxt (state_nxt),
    .cfg       (cfg_r),
    .motor_nxt (motor_nxt)
  );

  // Result register: load on update, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (res_free) begin
      res_vld_r <= smp_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_motor_r <= motor_nxt;
      res_state_r <= state_nxt;
    end
  end

  assign out_valid         = res_vld_r;
  assign out_motor_forward = res_motor_r;
  assign out_paper_state   = res_state_r;

  a_state_code_legal: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld_r |-> (res_state_r != 2'd3))
    else $error("result carries an unused paper state code");

  a_step_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> res_vld_r)
    else $error("update stage fired but result register is empty");

endmodule

### tb/sv/testbench.sv
module testbench;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic                  motor_forward;
    pfc_pkg::paper_state_t paper_state;
  } feed_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_sensor_level;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_motor_forward;
  logic [1:0]            out_paper_state;
  logic                  cfg_we;
  pfc_pkg::cfg_idx_t     cfg_index;
  pfc_pkg::cnt_t         cfg_wdata;

  // Predicted controller state and its copy of the registers
  pfc_pkg::cnt_t         limit_cfg;
  pfc_pkg::cnt_t         ticks_cfg;
  pfc_pkg::cnt_t         low_streak;
  pfc_pkg::cnt_t         high_streak;
  pfc_pkg::paper_state_t paper_now;
  logic                  feeding;
  logic                  feed_done;
  logic                  timer_live;
  pfc_pkg::cnt_t         feed_timer;
  logic                  motor_pred;

  feed_result_t result_q[$];
  int unsigned  mismatches;
  int unsigned  cycles;
  int           stall_left;
  bit           quiet;

  paper_feed_controller dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sensor_level   (in_sensor_level),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_motor_forward (out_motor_forward),
    .out_paper_state   (out_paper_state),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Advance the debouncer and feed timer by one sensor sample
  function automatic feed_result_t predict_tick(logic level);
    pfc_pkg::cnt_t prior;
    feed_result_t  res;
    if (!level) begin
      prior       = low_streak;
      high_streak = '0;
      low_streak  = prior + 16'd1;
      if (prior >= limit_cfg) begin
        low_streak = '0;
        paper_now  = pfc_pkg::ST_NO_PAPER;
      end
    end else begin
      prior       = high_streak;
      low_streak  = '0;
      high_streak = prior + 16'd1;
      if (prior >= limit_cfg) begin
        high_streak = '0;
        paper_now   = pfc_pkg::ST_HAS_PAPER;
      end
    end
    if (paper_now == pfc_pkg::ST_NO_PAPER) begin
      if (!feeding) begin
        feeding    = 1'b1;
        feed_done  = 1'b0;
        timer_live = 1'b0;
        motor_pred = 1'b1;
      end
    end else if (paper_now == pfc_pkg::ST_HAS_PAPER) begin
      if (!timer_live) begin
        feed_timer = '0;
        timer_live = 1'b1;
      end
      if (feed_timer != pfc_pkg::CNT_MAX) feed_timer = feed_timer + 16'd1;
      if (feed_timer >= ticks_cfg && !feed_done) begin
        feeding    = 1'b0;
        feed_done  = 1'b1;
        motor_pred = 1'b0;
      end
    end
    res.motor_forward = motor_pred;
    res.paper_state   = paper_now;
    return res;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (quiet || r < 55) return 0;
    if (r < 90) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 40));
  endfunction

  // Offer one sample word and hold it until it is taken
  task automatic send_sample(logic level);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_sensor_level <= level;
    do @(posedge clk); while (!in_ready);
    result_q.push_back(predict_tick(level));
  endtask

  task automatic send_run(logic level, int count);
    repeat (count) send_sample(level);
  endtask

  // Drop valid and wait until every result word is back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register; the caller drops the write enable afterwards
  task automatic write_reg(pfc_pkg::cfg_idx_t idx, pfc_pkg::cnt_t value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    if (idx == pfc_pkg::REG_DEBOUNCE_LIMIT) limit_cfg = value;
    else if (idx == pfc_pkg::REG_RUN_TICKS) ticks_cfg = value;
  endtask

  task automatic set_config(pfc_pkg::cnt_t limit, pfc_pkg::cnt_t ticks);
    drain_results();
    write_reg(pfc_pkg::REG_DEBOUNCE_LIMIT, limit);
    write_reg(pfc_pkg::REG_RUN_TICKS, ticks);
    cfg_we <= 1'b0;
  endtask

  // Reset values: stays idle through noise, then fires on the eleventh low
  task automatic test_reset_defaults();
    send_sample(1'b1);
    send_sample(1'b0);
    send_sample(1'b1);
    send_sample(1'b0);
    send_run(1'b0, 11);
  endtask

  // Zero limit and zero run time: each sample fires, motor stops at once
  task automatic test_zero_settings();
    set_config(16'd0, 16'd0);
    send_sample(1'b1);
    send_sample(1'b0);
    send_sample(1'b1);
  endtask

  // Timer keeps its count across a no-paper spell within the same feed
  task automatic test_timer_hold();
    set_config(16'd0, 16'd3);
    send_sample(1'b0);
    send_sample(1'b1);
    send_sample(1'b0);
    send_sample(1'b1);
    send_sample(1'b1);
    send_sample(1'b0);
  endtask

  // Largest limit: long runs of either level never fire
  task automatic test_largest_limit();
    set_config(pfc_pkg::CNT_MAX, 16'd1);
    send_run(1'b0, 12);
    send_sample(1'b1);
    send_run(1'b1, 12);
  endtask

  // Longest run time: motor keeps running through a long has-paper spell
  task automatic test_long_run_time();
    set_config(16'd0, pfc_pkg::CNT_MAX);
    quiet = 1'b1;
    send_sample(1'b0);
    send_run(1'b1, 40);
    send_sample(1'b0);
    send_run(1'b1, 3);
    quiet = 1'b0;
  endtask

  // Mostly full-length runs with random content, some broken runs and glitches
  task automatic random_phase(int items);
    int   sent;
    int   len;
    int   r;
    logic level;
    sent = 0;
    while (sent < items) begin
      r     = int'($urandom_range(0, 9));
      level = 1'($urandom_range(0, 1));
      if (r < 7) begin
        len = int'(limit_cfg) + 1;
        len += level ? int'($urandom_range(0, int'(ticks_cfg) + 2))
                     : int'($urandom_range(0, 3));
      end else if (r < 9) begin
        len = (limit_cfg == 0) ? 1 : int'($urandom_range(1, int'(limit_cfg)));
      end else begin
        len = 1;
      end
      send_run(level, len);
      sent += len;
    end
  endtask

  task automatic test_random();
    set_config(16'd0, 16'd0);
    random_phase(80);
    set_config(16'd1, 16'd5);
    random_phase(80);
    set_config(pfc_pkg::cnt_t'($urandom_range(2, 6)), pfc_pkg::cnt_t'($urandom_range(1, 20)));
    random_phase(80);
    set_config(16'd3, 16'd1);
    quiet = 1'b1;
    random_phase(80);
    quiet = 1'b0;
    set_config(pfc_pkg::cnt_t'($urandom_range(0, 8)), pfc_pkg::cnt_t'($urandom_range(0, 30)));
    random_phase(80);
  endtask

  // Compare each result word with the oldest prediction
  always @(posedge clk) begin
    feed_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        $error("result word with nothing expected: motor_forward %0d paper_state %0d",
               out_motor_forward, out_paper_state);
        mismatches++;
      end else begin
        want = result_q.pop_front();
        if (out_motor_forward !== want.motor_forward) begin
          $error("motor_forward: expected %0d, actual %0d",
                 want.motor_forward, out_motor_forward);
          mismatches++;
        end
        if (out_paper_state !== want.paper_state) begin
          $error("paper_state: expected %0d, actual %0d", want.paper_state, out_paper_state);
          mismatches++;
        end
      end
    end
  end

  // Stall the result side at random
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  // Abandon a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_sensor_level = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = pfc_pkg::REG_DEBOUNCE_LIMIT;
    cfg_wdata       = '0;
    quiet           = 1'b0;
    limit_cfg       = pfc_pkg::DEBOUNCE_LIMIT_RST;
    ticks_cfg       = pfc_pkg::RUN_TICKS_RST;
    low_streak      = '0;
    high_streak     = '0;
    paper_now       = pfc_pkg::ST_IDLE;
    feeding         = 1'b0;
    feed_done       = 1'b0;
    timer_live      = 1'b0;
    feed_timer      = '0;
    motor_pred      = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_zero_settings();
    test_timer_hold();
    test_largest_limit();
    test_long_run_time();
    test_random();

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
